>>> rtl/core/urb_pkg.sv
// Package with the command codes, error bits and constants of the serial ring buffers.
package urb_pkg;

	typedef enum logic [2:0] {
		CMD_LINE_RX  = 3'd0,
		CMD_GET_RX   = 3'd1,
		CMD_PUT_TX   = 3'd2,
		CMD_TX_READY = 3'd3,
		CMD_FLUSH_RX = 3'd4
	} cmd_t;

	localparam int unsigned ERR_W = 3;
	localparam int unsigned ERR_FRAME_BIT = 0;
	localparam int unsigned ERR_OVERRUN_BIT = 1;
	localparam logic [ERR_W-1:0] ERR_OVERFLOW = 3'b100;
	localparam logic [7:0] ERROR_CHAR = 8'h58;
	localparam int unsigned WAIT_W = 5;

endpackage

>>> rtl/core/urb_ifs.sv
// Request and response channel interfaces of the serial ring buffers.
interface urb_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] command;
	logic [7:0] byte_in;
	logic       frame_error;
	logic       data_overrun;

	modport source (output valid, command, byte_in, frame_error, data_overrun, input ready);
	modport sink (input valid, command, byte_in, frame_error, data_overrun, output ready);
endinterface

interface urb_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       rx_valid;
	logic [2:0] rx_error;
	logic [7:0] line_byte;
	logic       line_valid;
	logic       put_accepted;
	logic       tx_irq_enable;
	logic [4:0] rx_waiting;

	modport source (output valid, rx_byte, rx_valid, rx_error, line_byte, line_valid,
		put_accepted, tx_irq_enable, rx_waiting, input ready);
	modport sink (input valid, rx_byte, rx_valid, rx_error, line_byte, line_valid,
		put_accepted, tx_irq_enable, rx_waiting, output ready);
endinterface

>>> rtl/core/urb_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module urb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> rtl/core/uart_rx_tx_ring_buffers_unit.sv
// Top level of the serial receive and transmit ring buffers.
// A result passes the RAM read stage and then the output register after its request is accepted.
// Throughput: one request per cycle; input and read stage stall only when the output is held.
// Pointers, error bits and the interrupt enable live in flip-flops; the bytes live in two RAMs.
// Reset clears pointers, error bits, enable and stage valids at once; RAM contents are undefined.
// No clearing pass is needed, since an entry is only read after it has been written.
module uart_rx_tx_ring_buffers_unit #(
	parameter int unsigned RX_DEPTH = 32,
	parameter int unsigned TX_DEPTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	urb_req_if.sink  req,
	urb_rsp_if.source rsp
);

	localparam int unsigned RX_PW = $clog2(RX_DEPTH);
	localparam int unsigned TX_PW = $clog2(TX_DEPTH);

	// Ring pointers. Both rings keep one slot empty, so equal pointers mean empty.
	logic [RX_PW-1:0] rx_wr_q, rx_rd_q, rx_wr_d, rx_rd_d, rx_wr_nxt, rx_rd_nxt;
	logic [TX_PW-1:0] tx_wr_q, tx_rd_q, tx_wr_d, tx_rd_d, tx_wr_nxt, tx_rd_nxt;
	logic [urb_pkg::ERR_W-1:0] err_q, err_d, line_err;
	logic tx_en_q, tx_en_d;

	// RAM access requests for the accepted item.
	logic       rx_we, rx_re, tx_we, tx_re;
	logic [7:0] rx_wdata;
	logic [7:0] rx_rdata, tx_rdata;
	logic       put_ok;

	// The read stage holds everything of the result except the RAM data.
	logic       s1_valid_q;
	logic       rx_pop_s1, tx_pop_s1, put_ok_s1, tx_en_s1;
	logic [urb_pkg::ERR_W-1:0] err_s1;
	logic [urb_pkg::WAIT_W-1:0] wait_s1;

	logic       out_valid_q;
	logic       s1_adv, accept;

	logic [RX_PW:0] rx_diff;
	logic [RX_PW+urb_pkg::WAIT_W:0] rx_diff_ext;

	assign s1_adv   = !out_valid_q || rsp.ready;
	assign req.ready = !s1_valid_q || s1_adv;
	assign accept   = req.valid && req.ready;

	assign rx_wr_nxt = (rx_wr_q == RX_PW'(RX_DEPTH - 1)) ? '0 : rx_wr_q + 1'b1;
	assign rx_rd_nxt = (rx_rd_q == RX_PW'(RX_DEPTH - 1)) ? '0 : rx_rd_q + 1'b1;
	assign tx_wr_nxt = (tx_wr_q == TX_PW'(TX_DEPTH - 1)) ? '0 : tx_wr_q + 1'b1;
	assign tx_rd_nxt = (tx_rd_q == TX_PW'(TX_DEPTH - 1)) ? '0 : tx_rd_q + 1'b1;

	always_comb begin
		line_err = '0;
		line_err[urb_pkg::ERR_FRAME_BIT] = req.frame_error;
		line_err[urb_pkg::ERR_OVERRUN_BIT] = req.data_overrun;
	end

	// Command decode: pointer updates and the RAM access for one request.
	// A write goes to the advanced write pointer, a read to the advanced read pointer.
	always_comb begin
		rx_wr_d  = rx_wr_q;
		rx_rd_d  = rx_rd_q;
		tx_wr_d  = tx_wr_q;
		tx_rd_d  = tx_rd_q;
		err_d    = err_q;
		tx_en_d  = tx_en_q;
		rx_we    = 1'b0;
		rx_re    = 1'b0;
		tx_we    = 1'b0;
		tx_re    = 1'b0;
		put_ok   = 1'b0;
		rx_wdata = (line_err != '0) ? urb_pkg::ERROR_CHAR : req.byte_in;
		case (urb_pkg::cmd_t'(req.command))
			urb_pkg::CMD_LINE_RX: begin
				// A full receive ring drops the byte and reports only the overflow.
				if (rx_wr_nxt == rx_rd_q) begin
					err_d = urb_pkg::ERR_OVERFLOW;
				end else begin
					err_d   = line_err;
					rx_wr_d = rx_wr_nxt;
					rx_we   = 1'b1;
				end
			end
			urb_pkg::CMD_GET_RX: begin
				if (rx_wr_q != rx_rd_q) begin
					rx_rd_d = rx_rd_nxt;
					rx_re   = 1'b1;
				end
			end
			urb_pkg::CMD_PUT_TX: begin
				// The enable is set even when a full ring refuses the byte.
				if (tx_wr_nxt != tx_rd_q) begin
					tx_wr_d = tx_wr_nxt;
					tx_we   = 1'b1;
					put_ok  = 1'b1;
				end
				tx_en_d = 1'b1;
			end
			urb_pkg::CMD_TX_READY: begin
				if (tx_wr_q == tx_rd_q) begin
					tx_en_d = 1'b0;
				end else begin
					tx_rd_d = tx_rd_nxt;
					tx_re   = 1'b1;
				end
			end
			urb_pkg::CMD_FLUSH_RX: begin
				rx_wr_d = rx_rd_q;
			end
			default: begin
			end
		endcase
	end

	// Waiting count is (write - read) mod depth on the updated pointers, cut to five bits.
	always_comb begin
		if (rx_wr_d >= rx_rd_d) begin
			rx_diff = {1'b0, rx_wr_d} - {1'b0, rx_rd_d};
		end else begin
			rx_diff = {1'b0, rx_wr_d} + (RX_PW + 1)'(RX_DEPTH) - {1'b0, rx_rd_d};
		end
		rx_diff_ext = (RX_PW + urb_pkg::WAIT_W + 1)'(rx_diff);
	end

	urb_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
		.clk     (clk),
		.wr_en   (accept && rx_we),
		.wr_addr (rx_wr_d),
		.wr_data (rx_wdata),
		.rd_en   (accept && rx_re),
		.rd_addr (rx_rd_d),
		.rd_data (rx_rdata)
	);

	urb_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
		.clk     (clk),
		.wr_en   (accept && tx_we),
		.wr_addr (tx_wr_d),
		.wr_data (req.byte_in),
		.rd_en   (accept && tx_re),
		.rd_addr (tx_rd_d),
		.rd_data (tx_rdata)
	);

	// State registers change only on an accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_wr_q <= '0;
			rx_rd_q <= '0;
			tx_wr_q <= '0;
			tx_rd_q <= '0;
			err_q   <= '0;
			tx_en_q <= 1'b0;
		end else if (accept) begin
			rx_wr_q <= rx_wr_d;
			rx_rd_q <= rx_rd_d;
			tx_wr_q <= tx_wr_d;
			tx_rd_q <= tx_rd_d;
			err_q   <= err_d;
			tx_en_q <= tx_en_d;
		end
	end

	// Read stage: the item waits here for the RAM data. The RAM output holds while
	// this stage stalls, because no new read is issued until it moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req.ready) begin
			s1_valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rx_pop_s1 <= rx_re;
			tx_pop_s1 <= tx_re;
			put_ok_s1 <= put_ok;
			tx_en_s1  <= tx_en_d;
			err_s1    <= err_d;
			wait_s1   <= rx_diff_ext[urb_pkg::WAIT_W-1:0];
		end
	end

	// Output register: the result waits here until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q && s1_adv) begin
			rsp.rx_byte       <= rx_pop_s1 ? rx_rdata : '0;
			rsp.rx_valid      <= rx_pop_s1;
			rsp.rx_error      <= err_s1;
			rsp.line_byte     <= tx_pop_s1 ? tx_rdata : '0;
			rsp.line_valid    <= tx_pop_s1;
			rsp.put_accepted  <= put_ok_s1;
			rsp.tx_irq_enable <= tx_en_s1;
			rsp.rx_waiting    <= wait_s1;
		end
	end

	assign rsp.valid = out_valid_q;

	// A non-empty transmit ring always has its interrupt enable set.
	a_tx_nonempty_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		(tx_wr_q != tx_rd_q) |-> tx_en_q)
		else $error("transmit ring holds bytes with the enable cleared");

	// The overflow error is never reported together with line error bits.
	a_overflow_alone: assert property (@(posedge clk) disable iff (!arst_n)
		err_q[2] |-> (err_q[1:0] == 2'b00))
		else $error("overflow error mixed with line error bits");

	// Requests are refused only while both the read stage and the output are occupied.
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (s1_valid_q && out_valid_q))
		else $error("request refused with room in the pipeline");

	// A stalled read stage keeps its item.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(rx_pop_s1) && $stable(tx_pop_s1)))
		else $error("read stage lost its item while stalled");

	// A get on a non-empty ring always produces a popped byte in the next stage.
	a_get_pops: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.command == urb_pkg::CMD_GET_RX && rx_wr_q != rx_rd_q)
		|=> (s1_valid_q && rx_pop_s1))
		else $error("get on a non-empty ring did not pop");

endmodule
